// ===== rtl/core/ihex_pkg.sv =====
// Shared types and constants for the hex record checker.
// Used by the parser, the result emitter and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ihex_pkg;

    localparam int MAX_RECORD_BYTES_DEFAULT = 16;

    localparam logic [7:0] START_CHAR   = 8'h3A;
    localparam logic [7:0] DIGIT_LIMIT  = 8'h3F;
    localparam logic [7:0] ALPHA_OFFSET = 8'h37;
    localparam logic [7:0] NIBBLE_MASK  = 8'h0F;
    localparam logic [7:0] TYPE_DATA    = 8'h00;
    localparam logic [7:0] TYPE_EOF     = 8'h01;

    typedef enum logic [2:0] {
        EV_DATA = 3'd0,
        EV_OK   = 3'd1,
        EV_EOF  = 3'd2,
        EV_CSUM = 3'd3,
        EV_ADDR = 3'd4,
        EV_TYPE = 3'd5,
        EV_LEN  = 3'd6
    } event_t;

    // One burst for the emitter: count data bytes from the buffer, then a status item.
    typedef struct packed {
        logic        valid;
        event_t      status;
        logic [15:0] address;
        logic [7:0]  count;
    } emit_job_t;

    typedef struct packed {
        logic busy;
        logic take;
    } emit_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/ihex_record_buf.sv =====
// Record byte buffer: one write port, one read port with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module ihex_record_buf #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ihex_parser.sv =====
// Character parser: decodes the record fields, checks them and fills the byte buffer.
// Depends on ihex_pkg; hands finished records and errors to the emitter as jobs.
`timescale 1ns / 1ps
`default_nettype none

module ihex_parser #(
    parameter int MAX_RECORD_BYTES = ihex_pkg::MAX_RECORD_BYTES_DEFAULT,
    parameter int CW = $clog2(MAX_RECORD_BYTES + 1),
    parameter int AW = (MAX_RECORD_BYTES > 1) ? $clog2(MAX_RECORD_BYTES) : 1
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [7:0]             character,
    input  wire logic                   cfg_write_en,
    input  wire logic [15:0]            cfg_write_data,
    input  wire ihex_pkg::emit_status_t emit_status,
    output ihex_pkg::emit_job_t         job,
    output logic                        mem_we,
    output logic      [AW-1:0]          mem_waddr,
    output logic      [7:0]             mem_wdata
);

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_LEN,
        PH_ADDR,
        PH_TYPE,
        PH_DATA,
        PH_SUM
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic                digit_reg, digit_next;
    logic [3:0]          high_nibble_reg, high_nibble_next;
    logic [7:0]          record_length_reg, record_length_next;
    logic [15:0]         record_address_reg, record_address_next;
    logic [7:0]          record_type_reg, record_type_next;
    logic [7:0]          running_sum_reg, running_sum_next;
    logic [15:0]         expected_address_reg, expected_address_next;
    logic [CW-1:0]       byte_index_reg, byte_index_next;
    logic                halted_reg, halted_next;
    ihex_pkg::emit_job_t job_reg, job_next;

    logic       accept;
    logic [7:0] digit_raw;
    logic [3:0] nibble;
    logic [7:0] byte_val;
    logic [7:0] sum_val;
    logic       is_eof;

    assign in_stall = job_reg.valid | emit_status.busy;
    assign accept   = in_valid & ~in_stall;
    assign job      = job_reg;

    assign digit_raw = (character > ihex_pkg::DIGIT_LIMIT) ?
                       (character - ihex_pkg::ALPHA_OFFSET) : character;
    assign nibble    = digit_raw[3:0] & ihex_pkg::NIBBLE_MASK[3:0];
    assign byte_val  = {high_nibble_reg, nibble};
    assign sum_val   = running_sum_reg + byte_val;
    assign is_eof    = (byte_val == ihex_pkg::TYPE_EOF) && (record_address_reg == 16'h0000);

    assign mem_waddr = byte_index_reg[AW-1:0];
    assign mem_wdata = byte_val;

    always_comb
    begin
        phase_next            = phase_reg;
        digit_next            = digit_reg;
        high_nibble_next      = high_nibble_reg;
        record_length_next    = record_length_reg;
        record_address_next   = record_address_reg;
        record_type_next      = record_type_reg;
        running_sum_next      = running_sum_reg;
        expected_address_next = expected_address_reg;
        byte_index_next       = byte_index_reg;
        halted_next           = halted_reg;
        job_next              = job_reg;
        mem_we                = 1'b0;

        if (emit_status.take)
        begin
            job_next.valid = 1'b0;
        end

        if (cfg_write_en)
        begin
            expected_address_next = cfg_write_data;
        end

        if (accept && !halted_reg)
        begin
            if (phase_reg == PH_WAIT)
            begin
                if (character == ihex_pkg::START_CHAR)
                begin
                    phase_next       = PH_LEN;
                    running_sum_next = 8'h00;
                    digit_next       = 1'b0;
                    byte_index_next  = '0;
                end
            end
            else if (!digit_reg)
            begin
                high_nibble_next = nibble;
                digit_next       = 1'b1;
            end
            else
            begin
                digit_next       = 1'b0;
                running_sum_next = sum_val;
                case (phase_reg)
                    PH_LEN:
                    begin
                        record_length_next = byte_val;
                        if (byte_val > 8'(MAX_RECORD_BYTES))
                        begin
                            halted_next = 1'b1;
                            phase_next  = PH_WAIT;
                            job_next    = '{valid: 1'b1, status: ihex_pkg::EV_LEN,
                                            address: 16'h0000, count: 8'h00};
                        end
                        else
                        begin
                            phase_next      = PH_ADDR;
                            byte_index_next = '0;
                        end
                    end
                    PH_ADDR:
                    begin
                        if (byte_index_reg == '0)
                        begin
                            record_address_next = {byte_val, 8'h00};
                            byte_index_next     = CW'(1);
                        end
                        else
                        begin
                            record_address_next = {record_address_reg[15:8], byte_val};
                            byte_index_next     = '0;
                            phase_next          = PH_TYPE;
                        end
                    end
                    PH_TYPE:
                    begin
                        record_type_next = byte_val;
                        if (!is_eof && record_address_reg != expected_address_reg)
                        begin
                            halted_next = 1'b1;
                            phase_next  = PH_WAIT;
                            job_next    = '{valid: 1'b1, status: ihex_pkg::EV_ADDR,
                                            address: record_address_reg, count: 8'h00};
                        end
                        else if (!is_eof && byte_val != ihex_pkg::TYPE_DATA)
                        begin
                            halted_next = 1'b1;
                            phase_next  = PH_WAIT;
                            job_next    = '{valid: 1'b1, status: ihex_pkg::EV_TYPE,
                                            address: record_address_reg, count: 8'h00};
                        end
                        else
                        begin
                            byte_index_next = '0;
                            phase_next = (record_length_reg != 8'h00) ? PH_DATA : PH_SUM;
                        end
                    end
                    PH_DATA:
                    begin
                        mem_we          = 1'b1;
                        byte_index_next = byte_index_reg + CW'(1);
                        if ((8'(byte_index_reg) + 8'd1) >= record_length_reg)
                        begin
                            phase_next = PH_SUM;
                        end
                    end
                    PH_SUM:
                    begin
                        if (sum_val != 8'h00)
                        begin
                            halted_next = 1'b1;
                            phase_next  = PH_WAIT;
                            job_next    = '{valid: 1'b1, status: ihex_pkg::EV_CSUM,
                                            address: record_address_reg, count: 8'h00};
                        end
                        else
                        begin
                            // A type of one can only get here as an end-of-file record.
                            job_next = '{valid: 1'b1,
                                         status: (record_type_reg == ihex_pkg::TYPE_EOF) ?
                                                 ihex_pkg::EV_EOF : ihex_pkg::EV_OK,
                                         address: record_address_reg,
                                         count: record_length_reg};
                            expected_address_next = expected_address_reg +
                                                    {8'h00, record_length_reg};
                            phase_next      = PH_WAIT;
                            byte_index_next = '0;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_WAIT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg            <= PH_WAIT;
            digit_reg            <= 1'b0;
            high_nibble_reg      <= 4'h0;
            record_length_reg    <= 8'h00;
            record_address_reg   <= 16'h0000;
            record_type_reg      <= 8'h00;
            running_sum_reg      <= 8'h00;
            expected_address_reg <= 16'h0000;
            byte_index_reg       <= '0;
            halted_reg           <= 1'b0;
            job_reg              <= '0;
        end
        else
        begin
            phase_reg            <= phase_next;
            digit_reg            <= digit_next;
            high_nibble_reg      <= high_nibble_next;
            record_length_reg    <= record_length_next;
            record_address_reg   <= record_address_next;
            record_type_reg      <= record_type_next;
            running_sum_reg      <= running_sum_next;
            expected_address_reg <= expected_address_next;
            byte_index_reg       <= byte_index_next;
            halted_reg           <= halted_next;
            job_reg              <= job_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ihex_emitter.sv =====
// Result emitter: reads the buffered record bytes and drives the output register.
// Depends on ihex_pkg; takes jobs from the parser and reads the byte buffer.
`timescale 1ns / 1ps
`default_nettype none

module ihex_emitter #(
    parameter int MAX_RECORD_BYTES = ihex_pkg::MAX_RECORD_BYTES_DEFAULT,
    parameter int CW = $clog2(MAX_RECORD_BYTES + 1),
    parameter int AW = (MAX_RECORD_BYTES > 1) ? $clog2(MAX_RECORD_BYTES) : 1
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire ihex_pkg::emit_job_t    job,
    output ihex_pkg::emit_status_t      emit_status,
    output logic                        mem_re,
    output logic      [AW-1:0]          mem_raddr,
    input  wire logic [7:0]             mem_rdata,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic      [2:0]             event_res,
    output logic      [7:0]             data_byte,
    output logic      [15:0]            byte_address,
    output logic                        last
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_STATUS
    } state_t;

    state_t           state_reg, state_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [15:0]      base_reg, base_next;
    logic [7:0]       count_reg, count_next;
    ihex_pkg::event_t status_reg, status_next;
    logic             out_valid_reg, out_valid_next;
    logic [2:0]       event_reg, event_next;
    logic [7:0]       data_reg, data_next;
    logic [15:0]      addr_reg, addr_next;
    logic             last_reg, last_next;

    logic out_free;

    assign out_free     = ~out_valid_reg | ~out_stall;
    assign out_valid    = out_valid_reg;
    assign event_res    = event_reg;
    assign data_byte    = data_reg;
    assign byte_address = addr_reg;
    assign last         = last_reg;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        base_next      = base_reg;
        count_next     = count_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg & out_stall;
        event_next     = event_reg;
        data_next      = data_reg;
        addr_next      = addr_reg;
        last_next      = last_reg;
        mem_re         = 1'b0;
        mem_raddr      = '0;
        emit_status.busy = (state_reg != ST_IDLE);
        emit_status.take = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (job.valid && out_free)
                begin
                    emit_status.take = 1'b1;
                    base_next   = job.address;
                    count_next  = job.count;
                    status_next = job.status;
                    idx_next    = '0;
                    if (job.count == 8'h00)
                    begin
                        out_valid_next = 1'b1;
                        event_next     = job.status;
                        data_next      = 8'h00;
                        addr_next      = job.address;
                        last_next      = 1'b1;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                // The read data for idx_reg is valid and held until it is loaded.
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    event_next     = ihex_pkg::EV_DATA;
                    data_next      = mem_rdata;
                    addr_next      = base_reg + 16'(idx_reg);
                    last_next      = 1'b0;
                    if ((8'(idx_reg) + 8'd1) == count_reg)
                    begin
                        state_next = ST_STATUS;
                    end
                    else
                    begin
                        idx_next  = idx_reg + CW'(1);
                        mem_re    = 1'b1;
                        mem_raddr = idx_next[AW-1:0];
                    end
                end
            end
            ST_STATUS:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    event_next     = status_reg;
                    data_next      = 8'h00;
                    addr_next      = base_reg;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            base_reg      <= 16'h0000;
            count_reg     <= 8'h00;
            status_reg    <= ihex_pkg::EV_OK;
            out_valid_reg <= 1'b0;
            event_reg     <= ihex_pkg::EV_DATA;
            data_reg      <= 8'h00;
            addr_reg      <= 16'h0000;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            base_reg      <= base_next;
            count_reg     <= count_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
            event_reg     <= event_next;
            data_reg      <= data_next;
            addr_reg      <= addr_next;
            last_reg      <= last_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/intel_hex_record_checker_core.sv =====
// Top level of the hex record checker: parser, record byte buffer and result emitter.
// Depends on ihex_pkg, ihex_parser, ihex_record_buf and ihex_emitter.
//
//   channel | handshake          | payload
//   --------+--------------------+----------------------------------------------
//   input   | in_valid, in_stall | character
//   output  | out_valid,out_stall| event_res, data_byte, byte_address, last
//   config  | cfg_write_en       | cfg_write_data (start address)
//
// Characters that cause no result are taken one per cycle while no job stalls the input.
// A good record gives length+1 results: a buffer read, then one result per cycle unless
// out_stall holds, paced by the buffer's single read port; the input stalls during that burst.
// A request may be taken while the final result of a burst waits in the output register.
// Reset is asynchronous and needs no clearing pass; the buffer is always written before read.
`timescale 1ns / 1ps
`default_nettype none

module intel_hex_record_checker_core #(
    parameter int MAX_RECORD_BYTES = ihex_pkg::MAX_RECORD_BYTES_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  character,
    input  wire logic        cfg_write_en,
    input  wire logic [15:0] cfg_write_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [2:0]  event_res,
    output logic      [7:0]  data_byte,
    output logic      [15:0] byte_address,
    output logic             last
);

    localparam int CW = $clog2(MAX_RECORD_BYTES + 1);
    localparam int AW = (MAX_RECORD_BYTES > 1) ? $clog2(MAX_RECORD_BYTES) : 1;

    ihex_pkg::emit_job_t    job;
    ihex_pkg::emit_status_t emit_status;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [7:0]             mem_wdata;
    logic                   mem_re;
    logic [AW-1:0]          mem_raddr;
    logic [7:0]             mem_rdata;

    ihex_parser #(
        .MAX_RECORD_BYTES(MAX_RECORD_BYTES),
        .CW(CW),
        .AW(AW)
    ) u_parser (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .character(character),
        .cfg_write_en(cfg_write_en),
        .cfg_write_data(cfg_write_data),
        .emit_status(emit_status),
        .job(job),
        .mem_we(mem_we),
        .mem_waddr(mem_waddr),
        .mem_wdata(mem_wdata)
    );

    ihex_record_buf #(
        .DEPTH(MAX_RECORD_BYTES),
        .AW(AW)
    ) u_buf (
        .clk(clk),
        .we(mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .re(mem_re),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    ihex_emitter #(
        .MAX_RECORD_BYTES(MAX_RECORD_BYTES),
        .CW(CW),
        .AW(AW)
    ) u_emitter (
        .clk(clk),
        .rst_n(rst_n),
        .job(job),
        .emit_status(emit_status),
        .mem_re(mem_re),
        .mem_raddr(mem_raddr),
        .mem_rdata(mem_rdata),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .event_res(event_res),
        .data_byte(data_byte),
        .byte_address(byte_address),
        .last(last)
    );

endmodule

`default_nettype wire

// ===== tb/ihex_result_checker.sv =====
// Result checker for the hex record checker core: follows the character and start
// address traffic, predicts every result and compares the output stream against it.
// Depends on ihex_pkg for the event codes and the character constants.
`timescale 1ns / 1ps

module ihex_result_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  character,
    input  logic        cfg_write_en,
    input  logic [15:0] cfg_write_data,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  event_res,
    input  logic [7:0]  data_byte,
    input  logic [15:0] byte_address,
    input  logic        last,
    output int          mismatches,
    output int          pending,
    output int          results_seen
);

    localparam int BUF_BYTES = ihex_pkg::MAX_RECORD_BYTES_DEFAULT;

    typedef enum logic [2:0] {
        P_IDLE,
        P_LENGTH,
        P_ADDRESS,
        P_KIND,
        P_PAYLOAD,
        P_CHECKSUM
    } parse_phase_t;

    typedef struct {
        ihex_pkg::event_t kind;
        logic [7:0]       value;
        logic [15:0]      addr;
        logic             tail;
    } hex_result_t;

    parse_phase_t ph;
    logic         half;
    logic [3:0]   hi;
    logic [7:0]   rec_len;
    logic [15:0]  rec_addr;
    logic [7:0]   rec_type;
    logic [7:0]   sum;
    logic [15:0]  exp_addr;
    int           idx;
    logic [7:0]   rec_buf [BUF_BYTES];
    logic         halted;

    hex_result_t expected_results [$];

    task automatic expect_result(input ihex_pkg::event_t kind, input logic [7:0] value,
                                 input logic [15:0] addr, input logic tail);
        hex_result_t r;
        r.kind  = kind;
        r.value = value;
        r.addr  = addr;
        r.tail  = tail;
        expected_results.push_back(r);
    endtask

    // Any error freezes the parser until the next reset.
    task automatic stop_parse(input ihex_pkg::event_t kind, input logic [15:0] addr);
        halted = 1'b1;
        ph     = P_IDLE;
        expect_result(kind, 8'h00, addr, 1'b1);
    endtask

    task automatic parse_char(input logic [7:0] c);
        logic [7:0]  v;
        logic [7:0]  b;
        logic [15:0] a;
        logic        is_eof;
        if (!halted)
        begin
            if (ph == P_IDLE)
            begin
                if (c == ihex_pkg::START_CHAR)
                begin
                    ph   = P_LENGTH;
                    sum  = 8'h00;
                    half = 1'b0;
                    idx  = 0;
                end
            end
            else
            begin
                // Every character inside a record is taken as a digit, colon included.
                v = (c > ihex_pkg::DIGIT_LIMIT) ? c - ihex_pkg::ALPHA_OFFSET
                                                : c & ihex_pkg::NIBBLE_MASK;
                if (!half)
                begin
                    hi   = v[3:0];
                    half = 1'b1;
                end
                else
                begin
                    half = 1'b0;
                    b    = {hi, v[3:0]};
                    sum  = sum + b;
                    case (ph)
                        P_LENGTH:
                        begin
                            rec_len = b;
                            if (b > BUF_BYTES)
                            begin
                                stop_parse(ihex_pkg::EV_LEN, 16'h0000);
                            end
                            else
                            begin
                                ph  = P_ADDRESS;
                                idx = 0;
                            end
                        end
                        P_ADDRESS:
                        begin
                            if (idx == 0)
                            begin
                                rec_addr = {b, 8'h00};
                                idx      = 1;
                            end
                            else
                            begin
                                rec_addr[7:0] = b;
                                idx           = 0;
                                ph            = P_KIND;
                            end
                        end
                        P_KIND:
                        begin
                            is_eof   = (b == ihex_pkg::TYPE_EOF) && (rec_addr == 16'h0000);
                            rec_type = b;
                            if (!is_eof && rec_addr != exp_addr)
                            begin
                                stop_parse(ihex_pkg::EV_ADDR, rec_addr);
                            end
                            else if (!is_eof && b != ihex_pkg::TYPE_DATA)
                            begin
                                stop_parse(ihex_pkg::EV_TYPE, rec_addr);
                            end
                            else
                            begin
                                idx = 0;
                                ph  = (rec_len > 0) ? P_PAYLOAD : P_CHECKSUM;
                            end
                        end
                        P_PAYLOAD:
                        begin
                            if (idx < BUF_BYTES) rec_buf[idx] = b;
                            idx++;
                            if (idx >= rec_len) ph = P_CHECKSUM;
                        end
                        P_CHECKSUM:
                        begin
                            if (sum != 8'h00)
                            begin
                                stop_parse(ihex_pkg::EV_CSUM, rec_addr);
                            end
                            else
                            begin
                                for (int i = 0; i < rec_len && i < BUF_BYTES; i++)
                                begin
                                    a = rec_addr + 16'(i);
                                    expect_result(ihex_pkg::EV_DATA, rec_buf[i], a, 1'b0);
                                end
                                if (rec_type == ihex_pkg::TYPE_EOF)
                                    expect_result(ihex_pkg::EV_EOF, 8'h00, rec_addr, 1'b1);
                                else
                                    expect_result(ihex_pkg::EV_OK, 8'h00, rec_addr, 1'b1);
                                exp_addr = exp_addr + {8'h00, rec_len};
                                ph       = P_IDLE;
                                idx      = 0;
                            end
                        end
                        default: ph = P_IDLE;
                    endcase
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        hex_result_t want;
        if (!rst_n)
        begin
            ph       = P_IDLE;
            half     = 1'b0;
            hi       = 4'h0;
            rec_len  = 8'h00;
            rec_addr = 16'h0000;
            rec_type = 8'h00;
            sum      = 8'h00;
            exp_addr = 16'h0000;
            idx      = 0;
            halted   = 1'b0;
            expected_results.delete();
            pending  = 0;
        end
        else
        begin
            // Results go first: a request taken at this edge cannot answer at this edge.
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("result %0d unexpected: event %0d byte %02h addr %04h last %0b",
                                 results_seen, event_res, data_byte, byte_address, last);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (event_res !== want.kind || data_byte !== want.value ||
                        byte_address !== want.addr || last !== want.tail)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("result %0d wrong: expected event %0d byte %02h addr %04h last %0b",
                                     results_seen, want.kind, want.value, want.addr, want.tail);
                            $display("result %0d wrong: got event %0d byte %02h addr %04h last %0b",
                                     results_seen, event_res, data_byte, byte_address, last);
                        end
                        mismatches++;
                    end
                end
            end
            if (cfg_write_en) exp_addr = cfg_write_data;
            if (in_valid && !in_stall) parse_char(character);
            pending = expected_results.size();
        end
    end

endmodule

// ===== tb/intel_hex_record_checker_core_tb.sv =====
// Testbench top for the hex record checker core: drives characters and start
// addresses, stalls the result side and gives the verdict.
// Depends on ihex_pkg, the core RTL and ihex_result_checker.
`timescale 1ns / 1ps

module intel_hex_record_checker_core_tb;

    localparam int HOLD_CYCLES        = 300;
    localparam int WATCHDOG_LIMIT     = 3000;
    localparam int RECORD_CHAR_TARGET = 300;
    localparam int MIN_LOOP_RECORDS   = 6;

    typedef enum {FILL_ZERO, FILL_ONES, FILL_RANDOM} fill_t;
    typedef enum {BREAK_LENGTH, BREAK_ADDRESS, BREAK_KIND, BREAK_CHECKSUM} break_kind_t;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        in_valid       = 1'b0;
    logic [7:0]  character      = 8'h00;
    logic        cfg_write_en   = 1'b0;
    logic [15:0] cfg_write_data = 16'h0000;
    logic        out_stall      = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [2:0]  event_res;
    logic [7:0]  data_byte;
    logic [15:0] byte_address;
    logic        last;

    int          mismatches;
    int          pending;
    int          results_seen;

    int          gap_pct       = 22;
    bit          hold_req      = 1'b0;
    bit          hold_done     = 1'b0;
    logic [15:0] next_addr     = 16'h0000;
    int          record_chars  = 0;
    int          records_sent  = 0;
    int          settings_used = 0;
    break_kind_t brk;

    always #4 clk = ~clk;

    intel_hex_record_checker_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .character      (character),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .event_res      (event_res),
        .data_byte      (data_byte),
        .byte_address   (byte_address),
        .last           (last)
    );

    ihex_result_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .character      (character),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .event_res      (event_res),
        .data_byte      (data_byte),
        .byte_address   (byte_address),
        .last           (last),
        .mismatches     (mismatches),
        .pending        (pending),
        .results_seen   (results_seen)
    );

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        character <= c;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    // Plain hex digit, or some other character that decodes to the same nibble.
    function automatic logic [7:0] digit_char(input logic [3:0] n, input int weird_pct);
        logic [7:0] c;
        logic [7:0] v;
        if ($urandom_range(99) < weird_pct)
        begin
            do
            begin
                c = 8'($urandom);
                v = (c > ihex_pkg::DIGIT_LIMIT) ? c - ihex_pkg::ALPHA_OFFSET
                                                : c & ihex_pkg::NIBBLE_MASK;
            end
            while (v[3:0] != n);
        end
        else
        begin
            c = (n < 4'd10) ? 8'h30 + {4'h0, n} : 8'h37 + {4'h0, n};
        end
        return c;
    endfunction

    task automatic send_byte(input logic [7:0] b, input int weird_pct);
        send_char(digit_char(b[7:4], weird_pct));
        send_char(digit_char(b[3:0], weird_pct));
    endtask

    task automatic send_noise(input int count);
        logic [7:0] c;
        for (int i = 0; i < count; i++)
        begin
            do c = 8'($urandom); while (c == ihex_pkg::START_CHAR);
            send_char(c);
        end
    endtask

    task automatic send_record(input logic [7:0] len, input logic [15:0] addr,
                               input logic [7:0] kind, input fill_t fill,
                               input int weird_pct, input bit spoil);
        logic [7:0] sum;
        logic [7:0] b;
        sum = len + addr[15:8] + addr[7:0] + kind;
        send_char(ihex_pkg::START_CHAR);
        send_byte(len, weird_pct);
        send_byte(addr[15:8], weird_pct);
        send_byte(addr[7:0], weird_pct);
        send_byte(kind, weird_pct);
        for (int i = 0; i < len; i++)
        begin
            case (fill)
                FILL_ZERO: b = 8'h00;
                FILL_ONES: b = 8'hFF;
                default:   b = 8'($urandom);
            endcase
            send_byte(b, weird_pct);
            sum = sum + b;
        end
        sum = 8'h00 - sum;
        if (spoil) sum = sum + 8'($urandom_range(1, 255));
        send_byte(sum, weird_pct);
        record_chars += 11 + 2 * len;
        records_sent++;
        if (!spoil) next_addr = next_addr + {8'h00, len};
    endtask

    // Drop valid and wait until the block has nothing left to deliver.
    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_start(input logic [15:0] addr);
        settle();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= addr;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        next_addr = addr;
        settings_used++;
    endtask

    // Result side: random stalls, plus one long hold while requests keep coming.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            out_stall <= ($urandom_range(99) < gap_pct);
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        int          n;
        logic [15:0] bad_addr;
        logic [7:0]  kind;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_start(16'h0000);
        // Everything before the colon is dropped.
        send_char(8'h00);
        send_char(8'hFF);
        send_char(8'h55);
        send_char(8'hAA);
        send_record(8'd0, next_addr, ihex_pkg::TYPE_DATA, FILL_ZERO, 0, 1'b0);
        send_record(8'd16, next_addr, ihex_pkg::TYPE_DATA, FILL_ONES, 0, 1'b0);
        send_record(8'd16, next_addr, ihex_pkg::TYPE_DATA, FILL_ZERO, 0, 1'b0);
        // End-of-file record at address zero passes even though the expected address moved.
        send_record(8'd2, 16'h0000, ihex_pkg::TYPE_EOF, FILL_RANDOM, 100, 1'b0);

        set_start(16'hFFFF);
        send_record(8'd16, next_addr, ihex_pkg::TYPE_DATA, FILL_RANDOM, 0, 1'b0);
        set_start(16'hFFF8);

        hold_req = 1'b1;
        n = 0;
        while (record_chars < RECORD_CHAR_TARGET || n < MIN_LOOP_RECORDS)
        begin
            gap_pct = (n >= 2 && n < 6) ? 0 : 22;
            if (n > 0 && $urandom_range(99) < 12) set_start(16'($urandom_range(65535)));
            send_noise($urandom_range(3));
            if ($urandom_range(99) < 10)
                send_record(8'($urandom_range(16)), 16'h0000, ihex_pkg::TYPE_EOF,
                            FILL_RANDOM, 30, 1'b0);
            else
                send_record(8'($urandom_range(16)), next_addr, ihex_pkg::TYPE_DATA,
                            FILL_RANDOM, 30, 1'b0);
            n++;
        end
        gap_pct = 22;

        // Only one error fits in a run, since the parser stays halted until reset.
        settle();
        brk = break_kind_t'($urandom_range(3));
        case (brk)
            BREAK_LENGTH:
            begin
                send_char(ihex_pkg::START_CHAR);
                send_byte(8'($urandom_range(17, 255)), 30);
            end
            BREAK_ADDRESS:
            begin
                bad_addr = 16'($urandom_range(1, 65535));
                bad_addr = bad_addr ^ next_addr;
                if (next_addr != 16'h0000 && $urandom_range(1)) bad_addr = 16'h0000;
                send_char(ihex_pkg::START_CHAR);
                send_byte(8'($urandom_range(16)), 30);
                send_byte(bad_addr[15:8], 30);
                send_byte(bad_addr[7:0], 30);
                send_byte(ihex_pkg::TYPE_DATA, 30);
            end
            BREAK_KIND:
            begin
                kind = 8'($urandom_range(2, 255));
                if (next_addr != 16'h0000 && $urandom_range(1)) kind = ihex_pkg::TYPE_EOF;
                send_char(ihex_pkg::START_CHAR);
                send_byte(8'($urandom_range(16)), 30);
                send_byte(next_addr[15:8], 30);
                send_byte(next_addr[7:0], 30);
                send_byte(kind, 30);
            end
            default:
                send_record(8'($urandom_range(16)), next_addr, ihex_pkg::TYPE_DATA,
                            FILL_RANDOM, 30, 1'b1);
        endcase
        send_char(ihex_pkg::START_CHAR);
        send_noise(20);
        send_record(8'd4, next_addr, ihex_pkg::TYPE_DATA, FILL_RANDOM, 0, 1'b0);

        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);

        $display("Sent %0d records (%0d record characters) under %0d start addresses.",
                 records_sent, record_chars, settings_used);
        $display("Checked %0d results; the run closed with a %s break and dropped traffic.",
                 results_seen, brk.name());
        if (mismatches == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/ihex_pkg.sv
rtl/core/ihex_record_buf.sv
rtl/core/ihex_parser.sv
rtl/core/ihex_emitter.sv
rtl/core/intel_hex_record_checker_core.sv
tb/ihex_result_checker.sv
tb/intel_hex_record_checker_core_tb.sv
